// ===== rtl/core/ofx_pkg.sv =====
// Shared types, constants and helper functions of the overlapping frame extractor.
`default_nettype none

package ofx_pkg;

   // Ring of recent samples
   localparam int RING_DEPTH      = 64;
   localparam int RING_AW         = 6;

   // Longest window that the block frames
   localparam int MAX_PADDED      = 64;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int IN_SAMPLE_W     = 16;

   localparam int LEN_W           = 7;
   localparam int SHIFT_W         = 11;
   localparam int LOG_W           = 3;
   localparam int FRAME_W         = 16;
   localparam int VALUE_W         = 23;
   localparam int POS_W           = 6;

   localparam int CSR_ADDR_W      = 1;
   localparam int CSR_DATA_W      = 11;

   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 48;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_AW        = 1;
   localparam int WIN_N           = QUEUE_DEPTH + 1;

   localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd32;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 11'd16;
   localparam logic [SHIFT_W-1:0] CNT_RESET   = 11'd31;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WINDOW_LENGTH = 1'b0,
      REG_WINDOW_SHIFT  = 1'b1
   } csr_reg_type;

   // One frame to produce, handed from the front end to the back end
   typedef struct packed {
      logic [RING_AW-1:0] start;
      logic [LEN_W-1:0]   len;
      logic [LOG_W-1:0]   log2;
      logic [FRAME_W-1:0] frame;
   } job_type;

   // Ring span that a pending or active frame still has to read
   typedef struct packed {
      logic               valid;
      logic [RING_AW-1:0] start;
      logic [LEN_W-1:0]   len;
   } window_type;

   // Clamp the programmed length into 1..MAX_PADDED
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] l;
      l = raw;
      if (raw == '0) begin
         l = LEN_W'(1);
      end else if (raw > LEN_W'(MAX_PADDED)) begin
         l = LEN_W'(MAX_PADDED);
      end
      return l;
   endfunction

   function automatic logic [LOG_W-1:0] ceil_log2(input logic [LEN_W-1:0] n);
      logic [LOG_W-1:0] k;
      priority if (n <= 7'd1) begin
         k = 3'd0;
      end else if (n <= 7'd2) begin
         k = 3'd1;
      end else if (n <= 7'd4) begin
         k = 3'd2;
      end else if (n <= 7'd8) begin
         k = 3'd3;
      end else if (n <= 7'd16) begin
         k = 3'd4;
      end else if (n <= 7'd32) begin
         k = 3'd5;
      end else begin
         k = 3'd6;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ofx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ofx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/ofx_front.sv =====
// Front end: configuration, sample intake, ring writes and frame job issue.
`default_nettype none

module ofx_front #(
   parameter int SAMPLE_BITS = ofx_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ofx_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [ofx_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ofx_pkg::IN_SAMPLE_W-1:0]     req_sample,
   input  wire logic                                req_restart,
   input  wire ofx_pkg::window_type [ofx_pkg::WIN_N-1:0] windows,
   input  wire logic                                q_full,
   output logic                                     ram_we,
   output logic      [ofx_pkg::RING_AW-1:0]         ram_waddr,
   output logic      [SAMPLE_BITS-1:0]              ram_wdata,
   output logic                                     job_push,
   output ofx_pkg::job_type                         job
);

   logic [ofx_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [ofx_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [ofx_pkg::RING_AW-1:0] wp_ff, wp_in;
   logic [ofx_pkg::SHIFT_W-1:0] cnt_ff, cnt_in;
   logic [ofx_pkg::FRAME_W-1:0] fc_ff, fc_in;

   logic [ofx_pkg::LEN_W-1:0]   len_eff;
   logic [ofx_pkg::LOG_W-1:0]   len_log;
   logic [ofx_pkg::SHIFT_W-1:0] shift_eff;
   logic [ofx_pkg::RING_AW-1:0] wr_addr;
   logic [ofx_pkg::RING_AW-1:0] next_wp;
   logic [ofx_pkg::RING_AW-1:0] diff;
   logic                        conflict;
   logic                        accept;
   logic [ofx_pkg::SHIFT_W-1:0] cnt_base;
   logic [ofx_pkg::FRAME_W-1:0] frame_base;
   logic                        trigger;
   logic [SAMPLE_BITS-1:0]      sample_ext;

   // Rings wider than the field take it as an unsigned value
   if (SAMPLE_BITS <= ofx_pkg::IN_SAMPLE_W) begin : g_narrow
      assign sample_ext = req_sample[SAMPLE_BITS-1:0];
   end else begin : g_wide
      assign sample_ext = {{(SAMPLE_BITS - ofx_pkg::IN_SAMPLE_W){1'b0}}, req_sample};
   end

   always_comb begin
      len_eff    = ofx_pkg::eff_len(len_ff);
      len_log    = ofx_pkg::ceil_log2(len_eff);
      shift_eff  = (shift_ff == '0) ? ofx_pkg::SHIFT_W'(1) : shift_ff;
      wr_addr    = req_restart ? '0 : wp_ff;
      next_wp    = wr_addr + ofx_pkg::RING_AW'(1);

      // Hold the sample while its ring slot is still needed by a frame
      conflict = 1'b0;
      diff     = '0;
      for (int i = 0; i < ofx_pkg::WIN_N; i++) begin
         diff = wr_addr - windows[i].start;
         if (windows[i].valid && ({1'b0, diff} < windows[i].len)) begin
            conflict = 1'b1;
         end
      end

      req_tready = !conflict && !q_full;
      accept     = req_tvalid && req_tready;

      cnt_base   = req_restart ? (ofx_pkg::SHIFT_W'(len_eff) - ofx_pkg::SHIFT_W'(1)) : cnt_ff;
      frame_base = req_restart ? '0 : fc_ff;
      trigger    = (cnt_base == '0);

      len_in   = len_ff;
      shift_in = shift_ff;
      wp_in    = wp_ff;
      cnt_in   = cnt_ff;
      fc_in    = fc_ff;

      if (csr_we) begin
         unique case (ofx_pkg::csr_reg_type'(csr_addr))
            ofx_pkg::REG_WINDOW_LENGTH: begin
               len_in = csr_wdata[ofx_pkg::LEN_W-1:0];
            end
            ofx_pkg::REG_WINDOW_SHIFT: begin
               shift_in = csr_wdata;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
         // Any register write restarts framing
         wp_in  = '0;
         fc_in  = '0;
         cnt_in = ofx_pkg::SHIFT_W'(ofx_pkg::eff_len(len_in)) - ofx_pkg::SHIFT_W'(1);
      end else if (accept) begin
         wp_in = next_wp;
         if (trigger) begin
            cnt_in = shift_eff - ofx_pkg::SHIFT_W'(1);
            fc_in  = frame_base + ofx_pkg::FRAME_W'(1);
         end else begin
            cnt_in = cnt_base - ofx_pkg::SHIFT_W'(1);
            fc_in  = frame_base;
         end
      end

      ram_we    = accept;
      ram_waddr = wr_addr;
      ram_wdata = sample_ext;

      job_push  = accept && trigger;
      job.start = next_wp - ofx_pkg::RING_AW'(len_eff);
      job.len   = len_eff;
      job.log2  = len_log;
      job.frame = frame_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= ofx_pkg::LEN_RESET;
         shift_ff <= ofx_pkg::SHIFT_RESET;
         wp_ff    <= '0;
         cnt_ff   <= ofx_pkg::CNT_RESET;
         fc_ff    <= '0;
      end else begin
         len_ff   <= len_in;
         shift_ff <= shift_in;
         wp_ff    <= wp_in;
         cnt_ff   <= cnt_in;
         fc_ff    <= fc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ofx_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module ofx_queue (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       push,
   input  wire ofx_pkg::job_type                           push_job,
   input  wire logic                                       pop,
   output ofx_pkg::job_type                                head_job,
   output logic                                            head_valid,
   output logic                                            full,
   output ofx_pkg::job_type [ofx_pkg::QUEUE_DEPTH-1:0]     slots,
   output logic             [ofx_pkg::QUEUE_DEPTH-1:0]     slot_valid
);

   ofx_pkg::job_type [ofx_pkg::QUEUE_DEPTH-1:0] slot_ff, slot_in;
   logic [ofx_pkg::QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [ofx_pkg::QUEUE_AW-1:0]    wp_ff, wp_in;
   logic [ofx_pkg::QUEUE_AW-1:0]    rp_ff, rp_in;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      if (pop) begin
         valid_in[rp_ff] = 1'b0;
         rp_in           = rp_ff + ofx_pkg::QUEUE_AW'(1);
      end
      if (push) begin
         slot_in[wp_ff]  = push_job;
         valid_in[wp_ff] = 1'b1;
         wp_in           = wp_ff + ofx_pkg::QUEUE_AW'(1);
      end
   end

   assign head_job   = slot_ff[rp_ff];
   assign head_valid = valid_ff[rp_ff];
   assign full       = valid_ff[wp_ff];
   assign slots      = slot_ff;
   assign slot_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/ofx_back.sv =====
// Back end: window sum pass, then one value padded_size*x - window_sum per padded position.
`default_nettype none

module ofx_back #(
   parameter int SAMPLE_BITS = ofx_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             job_valid,
   input  wire ofx_pkg::job_type                 job,
   output logic                                  job_pop,
   output logic      [ofx_pkg::RING_AW-1:0]      ram_raddr,
   input  wire logic [SAMPLE_BITS-1:0]           ram_rdata,
   output ofx_pkg::window_type                   active,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [ofx_pkg::VALUE_W-1:0]      rsp_value,
   output logic      [ofx_pkg::POS_W-1:0]        rsp_pos,
   output logic                                  rsp_pad,
   output logic      [ofx_pkg::FRAME_W-1:0]      rsp_frame,
   output logic                                  rsp_last
);

   localparam int SUM_W  = SAMPLE_BITS + ofx_pkg::RING_AW;
   localparam int CALC_W = SUM_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [ofx_pkg::VALUE_W-1:0] value;
      logic [ofx_pkg::POS_W-1:0]   pos;
      logic                        pad;
      logic [ofx_pkg::FRAME_W-1:0] frame;
      logic                        last;
   } out_type;

   state_type                   state_ff, state_in;
   ofx_pkg::job_type            job_ff, job_in;
   logic [ofx_pkg::LEN_W-1:0]   idx_ff, idx_in;
   logic signed [SUM_W-1:0]     acc_ff, acc_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        rd_last_ff, rd_last_in;
   logic                        rd_pad_ff, rd_pad_in;
   logic [ofx_pkg::POS_W-1:0]   rd_pos_ff, rd_pos_in;
   out_type                     out_ff [2];
   out_type                     out_in [2];
   logic                        out_wp_ff, out_wp_in;
   logic                        out_rp_ff, out_rp_in;
   logic [1:0]                  out_cnt_ff, out_cnt_in;

   logic [ofx_pkg::LEN_W-1:0]   psize;
   logic                        rsp_pop;
   logic                        room;
   logic                        out_push;
   logic [SAMPLE_BITS-1:0]      rd_x;
   logic signed [CALC_W-1:0]    x_ext;
   logic signed [CALC_W-1:0]    s_ext;
   logic signed [CALC_W-1:0]    calc;
   out_type                     new_entry;

   always_comb begin
      psize   = ofx_pkg::LEN_W'(1) << job_ff.log2;
      rsp_pop = rsp_tvalid && rsp_tready;
      // Issue a read only if its result has a slot when it lands
      room    = (({1'b0, out_cnt_ff} + {2'b00, rd_pend_ff} - {2'b00, rsp_pop}) < 3'd2);

      rd_x  = rd_pad_ff ? '0 : ram_rdata;
      x_ext = {{(CALC_W - SAMPLE_BITS){rd_x[SAMPLE_BITS-1]}}, rd_x};
      s_ext = {acc_ff[SUM_W-1], acc_ff};
      calc  = (x_ext <<< job_ff.log2) - s_ext;

      new_entry.value = ofx_pkg::VALUE_W'(calc);
      new_entry.pos   = rd_pos_ff;
      new_entry.pad   = rd_pad_ff;
      new_entry.frame = job_ff.frame;
      new_entry.last  = rd_last_ff;

      ram_raddr = job_ff.start + idx_ff[ofx_pkg::RING_AW-1:0];

      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      rd_pend_in = 1'b0;
      rd_last_in = rd_last_ff;
      rd_pad_in  = rd_pad_ff;
      rd_pos_in  = rd_pos_ff;
      job_pop    = 1'b0;
      out_push   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job;
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (idx_ff < job_ff.len) begin
               rd_pend_in = 1'b1;
               rd_pad_in  = 1'b0;
               rd_last_in = ((idx_ff + ofx_pkg::LEN_W'(1)) == job_ff.len);
               idx_in     = idx_ff + ofx_pkg::LEN_W'(1);
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + {{ofx_pkg::RING_AW{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
               if (rd_last_ff) begin
                  state_in = ST_EMIT;
                  idx_in   = '0;
               end
            end
         end
         ST_EMIT: begin
            if ((idx_ff < psize) && room) begin
               rd_pend_in = 1'b1;
               rd_pos_in  = idx_ff[ofx_pkg::POS_W-1:0];
               rd_pad_in  = (idx_ff >= job_ff.len);
               rd_last_in = ((idx_ff + ofx_pkg::LEN_W'(1)) == psize);
               idx_in     = idx_ff + ofx_pkg::LEN_W'(1);
            end
            if (rd_pend_ff) begin
               out_push = 1'b1;
               if (rd_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_in     = out_ff;
      out_wp_in  = out_wp_ff;
      out_rp_in  = out_rp_ff;
      if (out_push) begin
         out_in[out_wp_ff] = new_entry;
         out_wp_in         = !out_wp_ff;
      end
      if (rsp_pop) begin
         out_rp_in = !out_rp_ff;
      end
      out_cnt_in = out_cnt_ff + {1'b0, out_push} - {1'b0, rsp_pop};
   end

   assign active.valid = (state_ff != ST_IDLE);
   assign active.start = job_ff.start;
   assign active.len   = job_ff.len;

   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_value  = out_ff[out_rp_ff].value;
   assign rsp_pos    = out_ff[out_rp_ff].pos;
   assign rsp_pad    = out_ff[out_rp_ff].pad;
   assign rsp_frame  = out_ff[out_rp_ff].frame;
   assign rsp_last   = out_ff[out_rp_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         out_wp_ff  <= 1'b0;
         out_rp_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
         out_wp_ff  <= out_wp_in;
         out_rp_ff  <= out_rp_in;
         out_cnt_ff <= out_cnt_in;
      end
      job_ff     <= job_in;
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      rd_last_ff <= rd_last_in;
      rd_pad_ff  <= rd_pad_in;
      rd_pos_ff  <= rd_pos_in;
      out_ff     <= out_in;
   end

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'd2)
      else $error("output buffer over capacity");

   a_read_only_busy: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff != ST_IDLE)
      else $error("ring read data returned while idle");

   a_sum_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> idx_ff <= job_ff.len)
      else $error("sum pass ran past the window");

endmodule

`default_nettype wire

// ===== rtl/core/overlapping_frame_extractor.sv =====
// Top level of the overlapping frame extractor: front end, job queue, back end, sample ring.
`default_nettype none

// Samples arrive one transaction at a time on req_ and are written into a
// 64-entry sample ring; frame k covers window_length samples starting at
// sample k*window_shift since the last restart (tuser set) or register write.
// When the last sample of a frame is taken, the front end queues a frame job
// and goes on accepting samples; the back end first sums the window out of
// the ring, then streams padded_size result transactions on rsp_, one per
// cycle while rsp_tready is high, each equal to padded_size*x - window_sum,
// with x the sample or zero for padding. Both passes share the single ring
// read port, and up to two further frames wait in the job queue. A sample is
// held off while the job queue is full or its ring slot still belongs to a
// queued or active window, so with short shifts the input runs at the pace
// of the back end. The ring needs no clearing after reset: no frame reads a
// slot before it is written. Configuration writes restart framing; the user
// must make them only while idle, as the block does not enforce this.
module overlapping_frame_extractor #(
   parameter int SAMPLE_BITS = ofx_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [ofx_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ofx_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // sample stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ofx_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] sample
   input  wire logic                              req_tuser,  // restart
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [ofx_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [22:0] frame_value,
                                                              // [28:23] position,
                                                              // [44:29] frame_number
   output logic                                   rsp_tuser,  // is_padding
   output logic                                   rsp_tlast   // last value of frame
);

   localparam int PAD_W = ofx_pkg::RSP_DATA_W
                        - (ofx_pkg::VALUE_W + ofx_pkg::POS_W + ofx_pkg::FRAME_W);

   ofx_pkg::window_type [ofx_pkg::WIN_N-1:0]     windows;
   ofx_pkg::job_type                             push_job;
   ofx_pkg::job_type                             head_job;
   ofx_pkg::job_type [ofx_pkg::QUEUE_DEPTH-1:0]  slots;
   logic [ofx_pkg::QUEUE_DEPTH-1:0]              slot_valid;
   ofx_pkg::window_type                          active;
   logic                                         job_push;
   logic                                         job_pop;
   logic                                         head_valid;
   logic                                         q_full;

   logic                                         ram_we;
   logic [ofx_pkg::RING_AW-1:0]                  ram_waddr;
   logic [SAMPLE_BITS-1:0]                       ram_wdata;
   logic [ofx_pkg::RING_AW-1:0]                  ram_raddr;
   logic [SAMPLE_BITS-1:0]                       ram_rdata;

   logic [ofx_pkg::VALUE_W-1:0]                  rsp_value;
   logic [ofx_pkg::POS_W-1:0]                    rsp_pos;
   logic [ofx_pkg::FRAME_W-1:0]                  rsp_frame;
   logic [ofx_pkg::RING_AW-1:0]                  clobber_diff;

   // Every ring span still to be read: queued jobs plus the active frame
   always_comb begin
      for (int i = 0; i < ofx_pkg::QUEUE_DEPTH; i++) begin
         windows[i].valid = slot_valid[i];
         windows[i].start = slots[i].start;
         windows[i].len   = slots[i].len;
      end
      windows[ofx_pkg::WIN_N-1] = active;
   end

   ofx_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_sample  (req_tdata[ofx_pkg::IN_SAMPLE_W-1:0]),
      .req_restart (req_tuser),
      .windows     (windows),
      .q_full      (q_full),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .job_push    (job_push),
      .job         (push_job)
   );

   ofx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (q_full),
      .slots      (slots),
      .slot_valid (slot_valid)
   );

   ofx_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (ofx_pkg::RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ofx_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .job_pop    (job_pop),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .active     (active),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_pos    (rsp_pos),
      .rsp_pad    (rsp_tuser),
      .rsp_frame  (rsp_frame),
      .rsp_last   (rsp_tlast)
   );

   // Pack result fields, lowest first; pad the top bits with zeros
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_frame, rsp_pos, rsp_value};

   assign clobber_diff = ram_waddr - active.start;

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !(active.valid && ({1'b0, clobber_diff} < active.len)))
      else $error("sample written into the window being framed");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("frame job pushed into a full queue");

endmodule

`default_nettype wire
